@@ rtl/flr_pkg.sv @@
`timescale 1ns / 1ps
package flr_pkg;

  localparam int unsigned SUM_W   = 48;
  localparam int unsigned FLUX_W  = 32;
  localparam int unsigned QP_W    = 31;
  localparam int unsigned MASS_W  = 32;
  localparam int unsigned NUM_W   = 64;
  localparam int unsigned RATIO_W = 17;
  localparam int unsigned STEP_W  = 5;

  // saturation limits of the two totals, kept as magnitudes
  localparam logic [SUM_W-1:0] NEG_SAT = 48'h8000_0000_0000;
  localparam logic [SUM_W-1:0] POS_SAT = 48'h7FFF_FFFF_FFFF;

  localparam logic [RATIO_W-1:0] ONE_Q16 = 17'h1_0000;
  localparam logic [STEP_W-1:0]  TOP_STEP = 5'd16;

  // one finished row handed from the front end to the back end
  typedef struct packed {
    logic [SUM_W-1:0]         neg_mag;
    logic [SUM_W-1:0]         pos_mag;
    logic signed [FLUX_W-1:0] qn;
    logic [QP_W-1:0]          qp;
    logic [MASS_W-1:0]        mass;
  } job_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_stat_t;

endpackage

@@ rtl/flr_front.sv @@
`timescale 1ns / 1ps
module flr_front
  import flr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic signed [FLUX_W-1:0] flux_i,
  input  logic                     skip_i,
  input  logic                     none_i,
  input  logic                     last_i,
  input  logic signed [FLUX_W-1:0] bound_neg_i,
  input  logic [QP_W-1:0]          bound_pos_i,
  input  logic [MASS_W-1:0]        mass_i,
  output logic                     push_o,
  output job_t                     job_o
);

  logic [SUM_W-1:0] neg_q, neg_d, pos_q, pos_d;
  logic [SUM_W:0]   neg_sum, pos_sum;
  logic [FLUX_W-1:0] flux_abs;
  logic             use_entry;

  assign use_entry = accept_i && !skip_i && !none_i;
  assign flux_abs  = ~flux_i + FLUX_W'(1);
  assign neg_sum   = {1'b0, neg_q} + (SUM_W+1)'(flux_abs);
  assign pos_sum   = {1'b0, pos_q} + (SUM_W+1)'(flux_i[FLUX_W-2:0]);

  always_comb begin
    neg_d = neg_q;
    pos_d = pos_q;
    if (use_entry) begin
      if (flux_i[FLUX_W-1] || flux_i == '0) begin
        neg_d = (neg_sum > {1'b0, NEG_SAT}) ? NEG_SAT : neg_sum[SUM_W-1:0];
      end else begin
        pos_d = (pos_sum > {1'b0, POS_SAT}) ? POS_SAT : pos_sum[SUM_W-1:0];
      end
    end
  end

  assign push_o        = accept_i && last_i;
  assign job_o.neg_mag = neg_d;
  assign job_o.pos_mag = pos_d;
  assign job_o.qn      = bound_neg_i;
  assign job_o.qp      = bound_pos_i;
  assign job_o.mass    = mass_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= '0;
      pos_q <= '0;
    end else if (push_o) begin
      neg_q <= '0;
      pos_q <= '0;
    end else begin
      neg_q <= neg_d;
      pos_q <= pos_d;
    end
  end

endmodule

@@ rtl/flr_queue.sv @@
`timescale 1ns / 1ps
module flr_queue
  import flr_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/flr_div.sv @@
`timescale 1ns / 1ps
module flr_div
  import flr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [SUM_W-1:0]   den_i,
  output logic               busy_o,
  output logic [RATIO_W-1:0] ratio_o
);

  logic [NUM_W-1:0]   rem_q, dsh_q, diff;
  logic [STEP_W-1:0]  cnt_q;
  logic [RATIO_W-1:0] quo_q;
  logic               busy_q, ge;

  assign ge      = rem_q >= dsh_q;
  assign diff    = rem_q - dsh_q;
  assign busy_o  = busy_q;
  assign ratio_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, 16'h0000};
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= diff;
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  // restoring division, one quotient bit a cycle from bit 16 down;
  // a set bit 16 means the ratio reached one and ends the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      cnt_q <= TOP_STEP;
      if (den_i == '0) begin
        quo_q  <= ONE_Q16;
        busy_q <= 1'b0;
      end else begin
        quo_q  <= '0;
        busy_q <= 1'b1;
      end
    end else if (busy_q) begin
      if (cnt_q == TOP_STEP && ge) begin
        quo_q  <= ONE_Q16;
        busy_q <= 1'b0;
      end else begin
        quo_q[cnt_q] <= ge;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - STEP_W'(1);
        end
      end
    end
  end

endmodule

@@ rtl/flr_back.sv @@
`timescale 1ns / 1ps
module flr_back
  import flr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  job_t                 job_i,
  output back_stat_t           stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2*RATIO_W-1:0] out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_DIV  = 3'b100
  } state_e;

  state_e state_q, state_d;
  job_t   job_q;

  logic [FLUX_W-1:0]  qn_abs;
  logic [NUM_W-1:0]   num_neg, num_pos;
  logic               start, busy_n, busy_p, out_free, load_out, pop;
  logic [RATIO_W-1:0] rn, rp;
  logic               valid_q;
  logic [2*RATIO_W-1:0] data_q;

  assign qn_abs   = ~job_q.qn + FLUX_W'(1);
  assign num_neg  = job_q.qn[FLUX_W-1] ? NUM_W'(qn_abs) * NUM_W'(job_q.mass) : '0;
  assign num_pos  = NUM_W'(job_q.qp) * NUM_W'(job_q.mass);
  assign start    = state_q == S_MUL;
  assign out_free = !valid_q || out_ready_i;
  assign load_out = state_q == S_DIV && !busy_n && !busy_p && out_free;
  assign pop      = state_q == S_IDLE && !empty_i;

  flr_div u_div_neg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .num_i   (num_neg),
    .den_i   (job_q.neg_mag),
    .busy_o  (busy_n),
    .ratio_o (rn)
  );

  flr_div u_div_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .num_i   (num_pos),
    .den_i   (job_q.pos_mag),
    .busy_o  (busy_p),
    .ratio_o (rp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (!empty_i) state_d = S_MUL;
      S_MUL:  state_d = S_DIV;
      S_DIV:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      job_q <= job_i;
    end
    if (load_out) begin
      data_q <= {rp, rn};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.busy = state_q != S_IDLE;
  assign stat_o.pop  = pop;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/fct_limiter_row_ratios.sv @@
`timescale 1ns / 1ps
// order: a row's ratios follow its tlast transfer through the queue, the product state,
//   both divisions (cut short by a zero total or a ratio of one) and any output stall
// throughput: one flux entry per cycle; the back end takes a new row only once the
//   17-step restoring divider pair is done and its result loaded; QUEUE_DEPTH finished
//   rows wait between front and back, and the input stalls only while that queue is full
// reset: rst_ni low clears both totals, the row queue and the output valid flag
module fct_limiter_row_ratios
  import flr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4  // 2 or more rows in flight
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] flux, [63:32] bound_neg, [94:64] bound_pos, [126:95] lumped_mass, [127] zero
  input  logic [127:0] s_axis_tdata,
  // [0] skip_entry, [1] no_flux
  input  logic [1:0]   s_axis_tuser,
  // row_end
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [16:0] ratio_neg, [33:17] ratio_pos, [39:34] zero
  output logic [39:0]  m_axis_tdata
);

  // queue between the accumulating front end and the dividing back end
  logic       accept, push, q_full, q_empty;
  job_t       job_in, job_out;
  back_stat_t back_stat;
  logic [2*RATIO_W-1:0] ratios;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // front end: sums unflagged transfers into the saturating totals, hands the row on at tlast
  flr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .flux_i      (s_axis_tdata[31:0]),
    .skip_i      (s_axis_tuser[0]),
    .none_i      (s_axis_tuser[1]),
    .last_i      (s_axis_tlast),
    .bound_neg_i (s_axis_tdata[63:32]),
    .bound_pos_i (s_axis_tdata[94:64]),
    .mass_i      (s_axis_tdata[126:95]),
    .push_o      (push),
    .job_o       (job_in)
  );

  flr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (back_stat.pop),
    .job_o   (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back end: products, then both ratios divided side by side into the output register
  flr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .job_i       (job_out),
    .stat_o      (back_stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (ratios)
  );

  assign m_axis_tdata = {6'b000000, ratios};

  // the input only closes right after a row was pushed into the queue
  a_stall_after_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tlast))
    else $error("input stalled without a pending row");

  // a new result only comes out of a busy back end
  a_result_from_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)) |-> $past(back_stat.busy))
    else $error("result appeared while back end idle");

  // ratios stay within zero to one
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:0] <= ONE_Q16 && m_axis_tdata[33:17] <= ONE_Q16))
    else $error("ratio above one");

endmodule
